// ===== hdl/lee_pkg.sv =====
// ============================================================================
// lee_pkg: shared types and constants of the local extrema detector
// Sample and index widths, request and record structs, record kinds,
// endpoint codes and the command/status bundles between control and data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package lee_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int INDEX_BITS  = 20;
  localparam int KIND_BITS   = 3;
  // magnitude of a difference of two samples
  localparam int MAG_BITS    = SAMPLE_BITS + 1;
  // magnitude times a position distance
  localparam int PROD_BITS   = MAG_BITS + INDEX_BITS;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [KIND_BITS-1:0] KIND_INT_MAX   = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_INT_MIN   = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_MAX_START = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_MAX_END   = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_MIN_START = 3'd4;
  localparam logic [KIND_BITS-1:0] KIND_MIN_END   = 3'd5;

  // endpoint sequence: bit 1 selects the minimum envelope, bit 0 the end
  localparam logic [1:0] EP_MAX_START = 2'd0;
  localparam logic [1:0] EP_MAX_END   = 2'd1;
  localparam logic [1:0] EP_MIN_START = 2'd2;
  localparam logic [1:0] EP_MIN_END   = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } lee_in_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]          kind;
    logic [INDEX_BITS-1:0]         position;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          last_of_run;
  } lee_out_t;

  typedef struct packed {
    logic       take;       // sample request accepted this cycle
    logic       prep;       // latch operands of the current endpoint
    logic       div_start;  // launch the divider
    logic       emit;       // load the endpoint record into the output register
    logic [1:0] ep;         // current endpoint
  } lee_cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a record this cycle
    logic calc;      // current endpoint needs extrapolation
    logic div_done;  // quotient ready
  } lee_sts_t;

endpackage

`default_nettype wire

// ===== hdl/lee_div.sv =====
// ============================================================================
// lee_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle; done pulses for one cycle
// with the quotient valid. The divisor must be nonzero.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lee_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [lee_pkg::PROD_BITS-1:0]  dividend,
  input  logic [lee_pkg::INDEX_BITS-1:0] divisor,
  output logic [lee_pkg::PROD_BITS-1:0]  quotient,
  output logic                           done
);
  import lee_pkg::*;

  localparam int CNT_BITS = $clog2(PROD_BITS + 1);

  logic                  busy;
  logic [CNT_BITS-1:0]   cnt;
  logic [INDEX_BITS-1:0] rem;
  logic [INDEX_BITS-1:0] dsr;
  logic [INDEX_BITS:0]   trial;
  logic [INDEX_BITS:0]   diff;
  logic                  ge;

  assign trial = {rem, quotient[PROD_BITS-1]};
  assign ge    = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(PROD_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      rem      <= ge ? diff[INDEX_BITS-1:0] : trial[INDEX_BITS-1:0];
      quotient <= {quotient[PROD_BITS-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lee_dp.sv =====
// ============================================================================
// lee_dp: datapath of the local extrema detector
// Sample window, extremum stores, endpoint operand selection, product and
// divider, saturation and the output record register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lee_dp (
  input  logic              clk,
  input  logic              rst,
  input  lee_pkg::lee_cmd_t cmd,
  output lee_pkg::lee_sts_t sts,
  input  lee_pkg::lee_in_t  sample_data,
  output logic              record_valid,
  input  logic              record_ready,
  output lee_pkg::lee_out_t record_data
);
  import lee_pkg::*;

  localparam int SUM_BITS = PROD_BITS + 2;
  localparam logic signed [SUM_BITS-1:0] SUM_MAX = SUM_BITS'(S_MAX);
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = SUM_BITS'(S_MIN);

  // sample window and series state
  logic signed [SAMPLE_BITS-1:0] prev, older, first, last_val;
  logic [INDEX_BITS-1:0]         idx, end_pos;
  logic [1:0]                    fill;
  logic [1:0]                    max_found, min_found;
  logic                          max_ok, min_ok;

  // first two and last two extrema of each kind
  logic [INDEX_BITS-1:0]         max_head_pos [2];
  logic signed [SAMPLE_BITS-1:0] max_head_val [2];
  logic [INDEX_BITS-1:0]         max_tail_pos [2];
  logic signed [SAMPLE_BITS-1:0] max_tail_val [2];
  logic [INDEX_BITS-1:0]         min_head_pos [2];
  logic signed [SAMPLE_BITS-1:0] min_head_val [2];
  logic [INDEX_BITS-1:0]         min_tail_pos [2];
  logic signed [SAMPLE_BITS-1:0] min_tail_val [2];

  logic signed [SAMPLE_BITS-1:0] s;
  logic [INDEX_BITS-1:0]         pp;
  logic                          is_max, is_min, max_rec, min_rec;
  logic [1:0]                    max_found_upd, min_found_upd;

  // endpoint operands
  logic                          ep_min, ep_end;
  logic [INDEX_BITS-1:0]         a_pos0, a_pos1, den, num;
  logic signed [SAMPLE_BITS-1:0] a_val0, a_val1, base, dflt;
  logic signed [SAMPLE_BITS:0]   dv;
  logic [MAG_BITS-1:0]           mag;
  logic [PROD_BITS-1:0]          prod;
  logic                          need;

  logic [PROD_BITS-1:0]          prod_r;
  logic [INDEX_BITS-1:0]         den_r;
  logic signed [SAMPLE_BITS-1:0] base_r, best_r;
  logic                          neg_r, calc_r;

  logic [PROD_BITS-1:0]          quo;
  logic                          div_done;
  logic signed [SUM_BITS-1:0]    base_ext, q_ext, sum;
  logic signed [SAMPLE_BITS-1:0] cand;
  logic                          better;

  logic                          out_free;
  lee_out_t                      int_rec, ep_rec;

  // interior extremum test against the incoming right neighbor
  assign s      = sample_data.sample;
  assign pp     = idx - 1'b1;
  assign is_max = (fill == 2'd2) && (prev > older) && (prev > s);
  assign is_min = (fill == 2'd2) && !is_max && (prev < older) && (prev < s);
  assign max_rec = cmd.take && is_max;
  assign min_rec = cmd.take && is_min;
  assign max_found_upd = (max_rec && max_found != 2'd2) ? max_found + 2'd1 : max_found;
  assign min_found_upd = (min_rec && min_found != 2'd2) ? min_found + 2'd1 : min_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      fill      <= '0;
      max_found <= '0;
      min_found <= '0;
    end else if (cmd.take) begin
      if (sample_data.last) begin
        idx       <= '0;
        fill      <= '0;
        max_found <= '0;
        min_found <= '0;
      end else begin
        idx       <= idx + 1'b1;
        fill      <= (fill == 2'd2) ? fill : fill + 2'd1;
        max_found <= max_found_upd;
        min_found <= min_found_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      older <= prev;
      prev  <= s;
      if (fill == 2'd0) begin
        first <= s;
      end
      if (sample_data.last) begin
        end_pos  <= idx;
        last_val <= s;
        max_ok   <= (max_found_upd == 2'd2);
        min_ok   <= (min_found_upd == 2'd2);
      end
    end
    if (max_rec) begin
      if (max_found != 2'd2) begin
        max_head_pos[max_found[0]] <= pp;
        max_head_val[max_found[0]] <= prev;
      end
      max_tail_pos[0] <= max_tail_pos[1];
      max_tail_val[0] <= max_tail_val[1];
      max_tail_pos[1] <= pp;
      max_tail_val[1] <= prev;
    end
    if (min_rec) begin
      if (min_found != 2'd2) begin
        min_head_pos[min_found[0]] <= pp;
        min_head_val[min_found[0]] <= prev;
      end
      min_tail_pos[0] <= min_tail_pos[1];
      min_tail_val[0] <= min_tail_val[1];
      min_tail_pos[1] <= pp;
      min_tail_val[1] <= prev;
    end
  end

  // select the pair of extrema nearest the current endpoint
  assign ep_min = cmd.ep[1];
  assign ep_end = cmd.ep[0];

  always_comb begin
    unique case (cmd.ep)
      EP_MAX_START: begin
        a_pos0 = max_head_pos[0]; a_pos1 = max_head_pos[1];
        a_val0 = max_head_val[0]; a_val1 = max_head_val[1];
      end
      EP_MAX_END: begin
        a_pos0 = max_tail_pos[0]; a_pos1 = max_tail_pos[1];
        a_val0 = max_tail_val[0]; a_val1 = max_tail_val[1];
      end
      EP_MIN_START: begin
        a_pos0 = min_head_pos[0]; a_pos1 = min_head_pos[1];
        a_val0 = min_head_val[0]; a_val1 = min_head_val[1];
      end
      default: begin
        a_pos0 = min_tail_pos[0]; a_pos1 = min_tail_pos[1];
        a_val0 = min_tail_val[0]; a_val1 = min_tail_val[1];
      end
    endcase
  end

  assign den  = a_pos1 - a_pos0;
  assign num  = ep_end ? (end_pos - a_pos1) : a_pos0;
  assign dv   = (SAMPLE_BITS+1)'(a_val1) - (SAMPLE_BITS+1)'(a_val0);
  assign mag  = dv[SAMPLE_BITS] ? MAG_BITS'(-dv) : MAG_BITS'(dv);
  assign prod = mag * num;
  assign base = ep_end ? a_val1 : a_val0;
  assign dflt = ep_end ? last_val : first;
  assign need = (ep_min ? min_ok : max_ok) && (den != '0);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      prod_r <= prod;
      den_r  <= den;
      base_r <= base;
      // the start point steps back from the head pair, the end forward
      neg_r  <= dv[SAMPLE_BITS] ^ !ep_end;
      best_r <= dflt;
    end else if (div_done && better) begin
      best_r <= cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calc_r <= 1'b0;
    end else if (cmd.prep) begin
      calc_r <= need;
    end
  end

  lee_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (den_r),
    .quotient (quo),
    .done     (div_done)
  );

  // apply the truncated term, saturate, keep it if it lies outside
  assign base_ext = SUM_BITS'(base_r);
  assign q_ext    = $signed({2'b00, quo});
  assign sum      = neg_r ? (base_ext - q_ext) : (base_ext + q_ext);

  always_comb begin
    priority if (sum > SUM_MAX) begin
      cand = S_MAX;
    end else if (sum < SUM_MIN) begin
      cand = S_MIN;
    end else begin
      cand = sum[SAMPLE_BITS-1:0];
    end
  end

  assign better = ep_min ? (cand < best_r) : (cand > best_r);

  // output record register
  always_comb begin
    int_rec.kind        = is_max ? KIND_INT_MAX : KIND_INT_MIN;
    int_rec.position    = pp;
    int_rec.value       = prev;
    int_rec.last_of_run = 1'b0;

    unique case (cmd.ep)
      EP_MAX_START: ep_rec.kind = KIND_MAX_START;
      EP_MAX_END:   ep_rec.kind = KIND_MAX_END;
      EP_MIN_START: ep_rec.kind = KIND_MIN_START;
      default:      ep_rec.kind = KIND_MIN_END;
    endcase
    ep_rec.position    = ep_end ? end_pos : '0;
    ep_rec.value       = best_r;
    ep_rec.last_of_run = (cmd.ep == EP_MIN_END);
  end

  assign out_free = !record_valid || record_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_valid <= 1'b0;
    end else if (max_rec || min_rec || cmd.emit) begin
      record_valid <= 1'b1;
    end else if (record_ready) begin
      record_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      record_data <= ep_rec;
    end else if (max_rec || min_rec) begin
      record_data <= int_rec;
    end
  end

  assign sts.out_free = out_free;
  assign sts.calc     = calc_r;
  assign sts.div_done = div_done;

endmodule

`default_nettype wire

// ===== hdl/lee_ctrl.sv =====
// ============================================================================
// lee_ctrl: controller of the local extrema detector
// Streams samples while idle; after the last sample steps through the four
// endpoint records: latch operands, divide when needed, emit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lee_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  input  logic              sample_last,
  output logic              sample_ready,
  input  lee_pkg::lee_sts_t sts,
  output lee_pkg::lee_cmd_t cmd
);
  import lee_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_START,
    S_DIV,
    S_EMIT
  } state_t;

  state_t     state;
  logic [1:0] ep;

  assign sample_ready  = (state == S_IDLE) && sts.out_free;
  assign cmd.take      = sample_valid && sample_ready;
  assign cmd.prep      = (state == S_PREP);
  assign cmd.div_start = (state == S_START) && sts.calc;
  assign cmd.emit      = (state == S_EMIT) && sts.out_free;
  assign cmd.ep        = ep;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ep    <= EP_MAX_START;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.take && sample_last) begin
            state <= S_PREP;
            ep    <= EP_MAX_START;
          end
        end
        S_PREP: begin
          state <= S_START;
        end
        S_START: begin
          state <= sts.calc ? S_DIV : S_EMIT;
        end
        S_DIV: begin
          if (sts.div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (sts.out_free) begin
            if (ep == EP_MIN_END) begin
              state <= S_IDLE;
            end else begin
              ep    <= ep + 2'd1;
              state <= S_PREP;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/local_extrema_with_end_extrapolation.sv =====
// ============================================================================
// local_extrema_with_end_extrapolation: streaming extrema and envelope ends
// Top level: controller, datapath and output register of the detector.
// ============================================================================
// Samples of a series arrive one per request; while the series runs the block
// takes one request every cycle that the record port keeps up, and reports each
// strict interior maximum or minimum in the cycle after the request that brings
// its right neighbor. The request flagged last closes the series and starts the
// endpoint phase: four records follow (max start, max end, min start, min end),
// the last one flagged last_of_run. Each endpoint passes a prep state that
// latches its operands, a start state, a divide state when it is extrapolated,
// in which the bit-serial divider forms one quotient bit per cycle, and an
// emit state that waits on the record port. No request is taken during the
// endpoint phase. Extrapolation through the two nearest interior extrema
// truncates toward zero and saturates to the sample range.
`timescale 1ns / 1ps
`default_nettype none

module local_extrema_with_end_extrapolation (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  lee_pkg::lee_in_t  sample_data,
  output logic              record_valid,
  input  logic              record_ready,
  output lee_pkg::lee_out_t record_data
);
  import lee_pkg::*;

  lee_cmd_t cmd;
  lee_sts_t sts;

  // sequence the series end and gate the sample request
  lee_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_last  (sample_data.last),
    .sample_ready (sample_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // hold window and stores, compute endpoints, drive the record register
  lee_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .sample_data  (sample_data),
    .record_valid (record_valid),
    .record_ready (record_ready),
    .record_data  (record_data)
  );

endmodule

`default_nettype wire

// ===== hdl/lee_check.sv =====
// ============================================================================
// lee_check: port-level checks of the local extrema detector
// Watches the top level ports and flags record ordering and handshake slips.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lee_check (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_ready,
  input lee_pkg::lee_in_t  sample_data,
  input logic              record_valid,
  input logic              record_ready,
  input lee_pkg::lee_out_t record_data
);
  import lee_pkg::*;

  // a stalled record holds
  a_rec_hold: assert property (@(posedge clk) disable iff (rst)
    record_valid && !record_ready |=> record_valid && $stable(record_data))
    else $error("record changed while stalled");

  // the endpoint phase starts right after the closing request
  a_end_stall: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready && sample_data.last |=> !sample_ready)
    else $error("request taken during endpoint phase");

  // only the min end record closes the series
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    record_valid |-> (record_data.last_of_run == (record_data.kind == KIND_MIN_END)))
    else $error("last_of_run on wrong record");

  // start records sit at position zero
  a_start_pos: assert property (@(posedge clk) disable iff (rst)
    record_valid && (record_data.kind == KIND_MAX_START ||
                     record_data.kind == KIND_MIN_START)
    |-> record_data.position == '0)
    else $error("start record off position zero");

endmodule

bind local_extrema_with_end_extrapolation lee_check u_check (.*);

`default_nettype wire
